[rtl/assert_macros.svh]
// Assertion helpers shared by the sparse-dense dot product RTL.
// Every check is sampled on the rising clock edge and is off while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property; the property may use |-> or |=>.
`define SDDP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition is never true.
`define SDDP_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/sddp_pkg.sv]
`default_nettype none
package sddp_pkg;

  localparam int MAX_LENGTH_DEF = 4096;
  localparam int REQ_W          = 2;
  localparam int POS_W          = 12;
  localparam int VAL_W          = 32;
  localparam int VLEN_W         = 13;
  localparam int SUM_W          = 48;
  localparam int PROD_W         = 2 * VAL_W;
  localparam int FRAC_W         = 16;
  // Wide enough to hold any store depth up to 65536.
  localparam int EXT_W          = 17;
  localparam int OUT_DEPTH      = 4;

  localparam logic [VLEN_W-1:0] VLEN_RESET = 13'd4096;
  // 1.0 in Q16.16: the weight of a binary term.
  localparam logic signed [VAL_W-1:0] WEIGHT_ONE = 32'sh0001_0000;
  localparam logic signed [SUM_W-1:0] ACC_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ACC_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD     = 2'd0,
    REQ_WEIGHTED = 2'd1,
    REQ_BINARY   = 2'd2
  } req_t;

  typedef struct packed {
    logic                    valid;
    logic                    last;
    logic                    bad;
    logic signed [VAL_W-1:0] weight;
  } term_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] dot_sum;
    logic                    index_error;
    logic                    overflow;
  } result_t;

endpackage
`default_nettype wire

[rtl/sddp_store.sv]
`default_nettype none
module sddp_store #(
  parameter int DEPTH  = sddp_pkg::MAX_LENGTH_DEF,
  parameter int ADDR_W = $clog2(sddp_pkg::MAX_LENGTH_DEF)
) (
  input  wire logic                           clk,
  input  wire logic [ADDR_W-1:0]              addr,
  input  wire logic                           wr_en,
  input  wire logic signed [sddp_pkg::VAL_W-1:0] wr_data,
  input  wire logic                           rd_en,
  output logic signed [sddp_pkg::VAL_W-1:0]   rd_data
);
  import sddp_pkg::*;

  logic signed [VAL_W-1:0] mem [DEPTH];
  logic signed [VAL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

[rtl/sddp_mac.sv]
`default_nettype none
`include "assert_macros.svh"
module sddp_mac (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire sddp_pkg::term_t                   term_in,
  input  wire logic signed [sddp_pkg::VAL_W-1:0] rd_data,
  output logic                                   res_valid,
  output sddp_pkg::result_t                      res
);
  import sddp_pkg::*;

  term_t                    s1_r;
  logic                     s2_valid_r, s2_last_r, s2_bad_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [SUM_W-1:0]  acc_r, acc_nxt;
  logic                     err_r, err_nxt;
  logic                     sat_r, sat_nxt;
  logic signed [SUM_W-1:0]  term48;
  logic signed [SUM_W:0]    sum49;
  logic signed [SUM_W-1:0]  sum48;
  logic                     clamp;

  // Store data arrives in the cycle after the read; the term info waits in s1_r.
  assign prod_nxt = $signed(s1_r.weight) * $signed(rd_data);

  // Arithmetic shift gives the floor of the Q32.32 product in Q32.16.
  assign term48 = prod_r[PROD_W-1:FRAC_W];
  assign sum49  = {acc_r[SUM_W-1], acc_r} + {term48[SUM_W-1], term48};
  assign clamp  = sum49[SUM_W] != sum49[SUM_W-1];

  always_comb begin
    if (clamp) begin
      sum48 = sum49[SUM_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sum48 = sum49[SUM_W-1:0];
    end
  end

  always_comb begin
    acc_nxt   = acc_r;
    err_nxt   = err_r;
    sat_nxt   = sat_r;
    res_valid = 1'b0;
    res       = '0;
    if (s2_valid_r) begin
      if (s2_bad_r) begin
        err_nxt = 1'b1;
      end else begin
        acc_nxt = sum48;
        if (clamp) begin
          sat_nxt = 1'b1;
        end
      end
      res.dot_sum     = acc_nxt;
      res.index_error = err_nxt;
      res.overflow    = sat_nxt;
      if (s2_last_r) begin
        // Emit the sum and start the next vector from zero.
        res_valid = 1'b1;
        acc_nxt   = '0;
        err_nxt   = 1'b0;
        sat_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r       <= '0;
      s2_valid_r <= 1'b0;
      s2_last_r  <= 1'b0;
      s2_bad_r   <= 1'b0;
      acc_r      <= '0;
      err_r      <= 1'b0;
      sat_r      <= 1'b0;
    end else begin
      s1_r       <= term_in;
      s2_valid_r <= s1_r.valid;
      s2_last_r  <= s1_r.last;
      s2_bad_r   <= s1_r.bad;
      acc_r      <= acc_nxt;
      err_r      <= err_nxt;
      sat_r      <= sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  `SDDP_ASSERT(a_bad_term_holds_acc, (s2_valid_r && s2_bad_r && !s2_last_r) |=> $stable(acc_r), "bad term changed the accumulator")
  `SDDP_ASSERT(a_result_clears_acc, res_valid |=> (acc_r == '0 && !err_r && !sat_r), "accumulator not cleared after result")

endmodule
`default_nettype wire

[rtl/sddp_ofifo.sv]
`default_nettype none
`include "assert_macros.svh"
module sddp_ofifo #(
  parameter int DEPTH = sddp_pkg::OUT_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire sddp_pkg::result_t   push_data,
  output logic                     pop_valid,
  input  wire logic                pop_ready,
  output sddp_pkg::result_t        pop_data
);
  import sddp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_t            mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               pop;

  assign pop_valid = cnt_r != '0;
  assign pop       = pop_valid & pop_ready;
  assign pop_data  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  `SDDP_NEVER(a_no_overflow, push && !pop && (cnt_r == CNT_W'(DEPTH)), "result queue overflow")

endmodule
`default_nettype wire

[rtl/sparse_dense_dot_product_unit.sv]
// Sparse-dense dot product. Load beats (req_type 0) write one Q16.16 element
// of the dense vector into an internal single-port store; term beats carry a
// sparse index and a Q16.16 weight (req_type 1) or an implied weight of 1.0
// (req_type 2). Each good term adds weight * dense[index] into a saturating
// 48-bit Q32.16 accumulator. Indices must rise strictly and stay below
// vector_length; a bad term is skipped and sets index_error. The term beat with
// last set emits dot_sum, index_error and overflow and clears the vector
// state. The block takes one beat per clock: the store port does one read
// or one write per cycle and the accumulate loop closes through acc_r alone.
// A sum reaches the output through the s1 and s2 stage registers and a
// four-entry result queue; input is held off only while four sums are
// queued or still in flight. Dense entries never loaded read as garbage.
// vector_length resets to 4096 and may be written only while idle.
`default_nettype none
`include "assert_macros.svh"
module sparse_dense_dot_product_unit #(
  parameter int MAX_LENGTH = sddp_pkg::MAX_LENGTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [sddp_pkg::REQ_W-1:0]         in_req_type,
  input  wire logic [sddp_pkg::POS_W-1:0]         in_position,
  input  wire logic signed [sddp_pkg::VAL_W-1:0]  in_value,
  input  wire logic                               in_last,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [sddp_pkg::SUM_W-1:0]       out_dot_sum,
  output logic                                    out_index_error,
  output logic                                    out_overflow,
  input  wire logic                               cfg_wr_en,
  input  wire logic [sddp_pkg::VLEN_W-1:0]        cfg_wr_data
);
  import sddp_pkg::*;

  localparam int ADDR_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int RSV_W  = $clog2(OUT_DEPTH + 1);
  localparam logic [EXT_W-1:0] MAX_LEN_V = EXT_W'(MAX_LENGTH);

  logic                   accept;
  logic                   is_load, is_term, is_binary;
  logic [EXT_W-1:0]       pos_ext;
  logic                   in_range;
  logic                   bad;
  logic [POS_W-1:0]       prev_r, prev_nxt;
  logic                   seen_r, seen_nxt;
  logic [VLEN_W-1:0]      vlen_r, vlen_nxt;
  logic [RSV_W-1:0]       rsv_r, rsv_nxt;
  logic                   rsv_inc, rsv_dec;
  logic signed [VAL_W-1:0] rd_data;
  term_t                  term;
  logic                   res_valid;
  result_t                res, out_res;

  assign accept   = in_valid & in_ready;
  assign pos_ext  = EXT_W'(in_position);
  assign in_range = pos_ext < MAX_LEN_V;

  always_comb begin
    is_load   = 1'b0;
    is_term   = 1'b0;
    is_binary = 1'b0;
    case (in_req_type)
      REQ_LOAD:     is_load = 1'b1;
      REQ_WEIGHTED: is_term = 1'b1;
      REQ_BINARY: begin
        is_term   = 1'b1;
        is_binary = 1'b1;
      end
      default: ;
    endcase
  end

  assign bad = (seen_r && (in_position <= prev_r)) ||
               ({1'b0, in_position} >= vlen_r) || !in_range;

  always_comb begin
    term        = '0;
    term.valid  = accept & is_term;
    term.last   = in_last;
    term.bad    = bad;
    term.weight = is_binary ? WEIGHT_ONE : in_value;
  end

  // Index tracking is settled at accept time so back-to-back terms see it.
  always_comb begin
    prev_nxt = prev_r;
    seen_nxt = seen_r;
    if (accept && is_term) begin
      if (!bad) begin
        prev_nxt = in_position;
        seen_nxt = 1'b1;
      end
      if (in_last) begin
        prev_nxt = '0;
        seen_nxt = 1'b0;
      end
    end
  end

  assign vlen_nxt = cfg_wr_en ? cfg_wr_data : vlen_r;

  // Reserve a queue slot for every sum from the moment its last term is taken.
  assign rsv_inc  = accept & is_term & in_last;
  assign rsv_dec  = out_valid & out_ready;
  assign rsv_nxt  = rsv_r + RSV_W'(rsv_inc) - RSV_W'(rsv_dec);
  assign in_ready = rsv_r < RSV_W'(OUT_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      seen_r <= 1'b0;
      vlen_r <= VLEN_RESET;
      rsv_r  <= '0;
    end else begin
      prev_r <= prev_nxt;
      seen_r <= seen_nxt;
      vlen_r <= vlen_nxt;
      rsv_r  <= rsv_nxt;
    end
  end

  sddp_store #(
    .DEPTH  (MAX_LENGTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .addr    (pos_ext[ADDR_W-1:0]),
    .wr_en   (accept & is_load & in_range),
    .wr_data (in_value),
    .rd_en   (accept & is_term),
    .rd_data (rd_data)
  );

  sddp_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .term_in   (term),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res       (res)
  );

  sddp_ofifo #(
    .DEPTH (OUT_DEPTH)
  ) u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .pop_valid (out_valid),
    .pop_ready (out_ready),
    .pop_data  (out_res)
  );

  assign out_dot_sum     = out_res.dot_sum;
  assign out_index_error = out_res.index_error;
  assign out_overflow    = out_res.overflow;

  `SDDP_NEVER(a_rsv_bound, rsv_r > RSV_W'(OUT_DEPTH), "reservation count above queue depth")
  `SDDP_ASSERT(a_out_reserved, out_valid |-> (rsv_r != '0), "result shown without a reservation")

endmodule
`default_nettype wire

[verif/sparse_dense_dot_product_unit_test.sv]
`default_nettype none
module sparse_dense_dot_product_unit_test;
  import sddp_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int DRAIN_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 8;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [REQ_W-1:0] in_req_type;
  logic [POS_W-1:0] in_position;
  logic signed [VAL_W-1:0] in_value;
  logic in_last;
  logic out_valid;
  logic out_ready;
  logic signed [SUM_W-1:0] out_dot_sum;
  logic out_index_error;
  logic out_overflow;
  logic cfg_wr_en;
  logic [VLEN_W-1:0] cfg_wr_data;

  sparse_dense_dot_product_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req_type(in_req_type),
    .in_position(in_position),
    .in_value(in_value),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_dot_sum(out_dot_sum),
    .out_index_error(out_index_error),
    .out_overflow(out_overflow),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Predictor state
  logic signed [VAL_W-1:0] dense_ref [MAX_LENGTH_DEF];
  logic signed [SUM_W-1:0] acc_ref;
  logic [POS_W-1:0] prev_index_ref;
  bit index_seen_ref;
  bit bad_term_ref;
  bit saturated_ref;
  logic [VLEN_W-1:0] length_ref;
  result_t sum_queue[$];

  // Store entries written so far; terms only ever address these
  bit loaded_map [MAX_LENGTH_DEF];
  int loaded_pos[$];

  int error_count = 0;
  bit gaps_on = 1'b1;
  int burst_left = 0;
  int hold_left = 0;
  int rx_cycle = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(4 * 500000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    if (error_count < 40)
      $display("ERROR: %s got %0d want %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  function automatic void clear_vector_ref();
    acc_ref = '0;
    prev_index_ref = '0;
    index_seen_ref = 1'b0;
    bad_term_ref = 1'b0;
    saturated_ref = 1'b0;
  endfunction

  function automatic void predict_beat(logic [REQ_W-1:0] req, logic [POS_W-1:0] pos,
                                       logic signed [VAL_W-1:0] val, bit last);
    longint term;
    longint total;
    result_t res;
    if (req == REQ_LOAD) begin
      dense_ref[pos] = val;
    end else if (req == REQ_WEIGHTED || req == REQ_BINARY) begin
      if ((index_seen_ref && pos <= prev_index_ref) || pos >= length_ref ||
          int'(pos) >= MAX_LENGTH_DEF) begin
        bad_term_ref = 1'b1;
      end else begin
        if (req == REQ_BINARY)
          term = longint'(dense_ref[pos]);
        else
          term = (longint'(val) * longint'(dense_ref[pos])) >>> FRAC_W;
        total = longint'(acc_ref) + term;
        if (total > longint'(ACC_MAX)) begin
          total = longint'(ACC_MAX);
          saturated_ref = 1'b1;
        end
        if (total < longint'(ACC_MIN)) begin
          total = longint'(ACC_MIN);
          saturated_ref = 1'b1;
        end
        acc_ref = total[SUM_W-1:0];
        prev_index_ref = pos;
        index_seen_ref = 1'b1;
      end
      if (last) begin
        res.dot_sum = acc_ref;
        res.index_error = bad_term_ref;
        res.overflow = saturated_ref;
        sum_queue.push_back(res);
        clear_vector_ref();
      end
    end
  endfunction

  // Result checker
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (sum_queue.size() == 0) begin
        report_mismatch("result with nothing pending, dot_sum", out_dot_sum, 0);
      end else begin
        want = sum_queue.pop_front();
        if (out_dot_sum !== want.dot_sum)
          report_mismatch("dot_sum", out_dot_sum, want.dot_sum);
        if (out_index_error !== want.index_error)
          report_mismatch("index_error", out_index_error, want.index_error);
        if (out_overflow !== want.overflow)
          report_mismatch("overflow", out_overflow, want.overflow);
      end
    end
  end

  // Receiver: long hold-off on request, else rotate through its stall patterns
  always @(negedge clk) begin
    rx_cycle++;
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      case ((rx_cycle / 400) % 3)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ((rx_cycle % 7) >= 3);
      endcase
    end
  end

  // Called and returns at a falling edge
  task automatic send_beat(logic [REQ_W-1:0] req, int pos, logic signed [VAL_W-1:0] val,
                           bit last);
    if (req == REQ_LOAD && !loaded_map[pos]) begin
      loaded_map[pos] = 1'b1;
      loaded_pos.push_back(pos);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_position <= pos[POS_W-1:0];
    in_value <= val;
    in_last <= last;
    do @(posedge clk); while (!in_ready);
    predict_beat(req, pos[POS_W-1:0], val, last);
    @(negedge clk);
    if (gaps_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        burst_left = $urandom_range(1, 12);
      end
    end
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (sum_queue.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (sum_queue.size() != 0) begin
      report_mismatch("results never delivered, count", 0, sum_queue.size());
      sum_queue.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_length(logic [VLEN_W-1:0] len);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= len;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    length_ref = len;
  endtask

  function automatic logic signed [VAL_W-1:0] pick_q16();
    int near_zero;
    near_zero = $urandom_range(0, 262143);
    case ($urandom_range(0, 7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2, 3: return near_zero - 131072;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_noise();
    case ($urandom_range(0, 2))
      0: send_beat(REQ_LOAD, $urandom_range(0, MAX_LENGTH_DEF - 1), pick_q16(),
                   1'($urandom_range(0, 1)));
      1: send_beat(REQ_UNUSED, loaded_pos[$urandom_range(0, loaded_pos.size() - 1)],
                   $urandom, 1'($urandom_range(0, 1)));
      default: send_beat(REQ_LOAD, loaded_pos[$urandom_range(0, loaded_pos.size() - 1)],
                         pick_q16(), 1'b0);
    endcase
  endtask

  task automatic send_vector(bit well_formed);
    int picks[$];
    int chosen[$];
    logic [REQ_W-1:0] kind;
    repeat ($urandom_range(1, 8))
      picks.push_back(loaded_pos[$urandom_range(0, loaded_pos.size() - 1)]);
    if (well_formed) begin
      picks.sort();
      foreach (picks[i])
        if (picks[i] < length_ref && (chosen.size() == 0 || picks[i] > chosen[$]))
          chosen.push_back(picks[i]);
    end
    // fall back to a scrambled index order when nothing usable is left
    if (chosen.size() == 0) begin
      picks.shuffle();
      chosen = picks;
    end
    foreach (chosen[i]) begin
      if ($urandom_range(0, 9) == 0)
        send_noise();
      kind = $urandom_range(0, 1) ? REQ_WEIGHTED : REQ_BINARY;
      send_beat(kind, chosen[i], pick_q16(), i == chosen.size() - 1);
    end
  endtask

  task automatic run_phase(logic [VLEN_W-1:0] len, int vectors, bit gaps);
    drain_results();
    write_length(len);
    gaps_on = gaps;
    repeat (vectors) begin
      case ($urandom_range(0, 9))
        0: send_noise();
        1: send_vector(1'b0);
        default: send_vector(1'b1);
      endcase
    end
  endtask

  task automatic test_directed_terms();
    send_beat(REQ_LOAD, 0, 32'sh7FFF_FFFF, 1'b0);
    send_beat(REQ_LOAD, 1, 32'sh7FFF_FFFF, 1'b0);
    send_beat(REQ_LOAD, 2, 32'sh7FFF_FFFF, 1'b0);
    send_beat(REQ_LOAD, 4095, 32'sh8000_0000, 1'b0);
    // last on a load must not close a vector
    send_beat(REQ_LOAD, 3, -32'sd1, 1'b1);
    // drive the sum past both rails
    send_beat(REQ_WEIGHTED, 0, 32'sh7FFF_FFFF, 1'b0);
    send_beat(REQ_WEIGHTED, 1, 32'sh7FFF_FFFF, 1'b0);
    send_beat(REQ_WEIGHTED, 2, 32'sh7FFF_FFFF, 1'b1);
    send_beat(REQ_WEIGHTED, 0, 32'sh8000_0000, 1'b0);
    send_beat(REQ_WEIGHTED, 1, 32'sh8000_0000, 1'b0);
    send_beat(REQ_WEIGHTED, 2, 32'sh8000_0000, 1'b1);
    // binary terms ignore value; repeated index and unused code in between
    send_beat(REQ_BINARY, 3, 32'sh1234_5678, 1'b0);
    send_beat(REQ_BINARY, 3, 32'sh0, 1'b0);
    send_beat(REQ_UNUSED, 3, 32'sh7FFF_FFFF, 1'b1);
    send_beat(REQ_BINARY, 4095, -32'sd1, 1'b1);
    // a bad term that is also the last one still closes the vector
    send_beat(REQ_WEIGHTED, 4095, WEIGHT_ONE, 1'b0);
    send_beat(REQ_WEIGHTED, 0, WEIGHT_ONE, 1'b1);
  endtask

  task automatic test_length_limits();
    drain_results();
    write_length(13'd0);
    send_beat(REQ_BINARY, 0, 32'sh0, 1'b1);
    drain_results();
    write_length(13'd1);
    send_beat(REQ_WEIGHTED, 0, WEIGHT_ONE, 1'b0);
    send_beat(REQ_WEIGHTED, 1, WEIGHT_ONE, 1'b1);
    drain_results();
    write_length(VLEN_RESET);
    send_beat(REQ_WEIGHTED, 4095, 32'sh0000_8000, 1'b1);
  endtask

  task automatic test_random_vectors();
    gaps_on = 1'b1;
    for (int p = 0; p < 128; p++)
      send_beat(REQ_LOAD, p, pick_q16(), 1'b0);
    for (int p = MAX_LENGTH_DEF - 128; p < MAX_LENGTH_DEF; p++)
      send_beat(REQ_LOAD, p, pick_q16(), 1'b0);
    run_phase(VLEN_RESET, 180, 1'b1);
    run_phase(13'd1, 15, 1'b1);
    run_phase(13'd300, 60, 1'b0);
    run_phase(13'd0, 8, 1'b1);
    run_phase(13'd4095, 60, 1'b0);
    run_phase(VLEN_W'($urandom_range(2, 4094)), 40, 1'b1);
    run_phase(VLEN_RESET, 10, 1'b1);
  endtask

  task automatic test_output_backpressure();
    drain_results();
    gaps_on = 1'b0;
    // hold the result side off so the queue fills and input stalls
    hold_left = 400;
    repeat (16)
      send_beat(REQ_BINARY, loaded_pos[$urandom_range(0, loaded_pos.size() - 1)],
                $urandom, 1'b1);
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_LOAD;
    in_position = '0;
    in_value = '0;
    in_last = 1'b0;
    out_ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    length_ref = VLEN_RESET;
    clear_vector_ref();
    burst_left = $urandom_range(1, 12);
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed_terms();
    test_length_limits();
    test_random_vectors();
    test_output_backpressure();
    drain_results();

    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire

[files.f]
+incdir+rtl
rtl/sddp_pkg.sv
rtl/sddp_store.sv
rtl/sddp_mac.sv
rtl/sddp_ofifo.sv
rtl/sparse_dense_dot_product_unit.sv
verif/sparse_dense_dot_product_unit_test.sv
